@@ rtl/vpp_pkg.sv @@
// Shared constants and scan-state type for the value-precedence propagator.
`default_nettype none

package vpp_pkg;

   // Sequence length limit and derived widths
   localparam int MAX_VARS = 256;
   localparam int POS_W    = $clog2(MAX_VARS + 1);
   localparam int IDX_W    = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;

   // Fixed field widths
   localparam int STATUS_W = 2;
   localparam int STRIP_W  = 9;
   localparam int FIDX_W   = 8;
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = 4;
   localparam int REGSEL_W = 2;

   // Verdict codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CONTRA   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ENTAILED = 2'd2;

   // Register indexes (byte address = 4 * index)
   localparam logic [REGSEL_W-1:0] REG_VALUE_S     = 2'd0;
   localparam logic [REGSEL_W-1:0] REG_VALUE_T     = 2'd1;
   localparam logic [REGSEL_W-1:0] REG_DIRECT_MODE = 2'd2;

   // Running scan state for one sequence
   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             first_s_found;
      logic [IDX_W-1:0] first_s_index;
      logic             first_s_is_fixed;
      logic             first_fixed_t_found;
      logic [IDX_W-1:0] first_fixed_t_index;
      logic             t_seen_before_gamma;
      logic [1:0]       s_support_count;
      logic             strip_happened;
      logic             strip_failed;
   } scan_state_type;

endpackage

`default_nettype wire

@@ rtl/value_precede_propagator.sv @@
// Value-precedence propagator: streaming scan with one verdict per sequence.
`default_nettype none

// Channel   | Handshake                  | Payload
// ----------+----------------------------+-------------------------------------------
// req       | req_valid / req_ready      | has_s, has_t, fixed_s, fixed_t, last_var
// rsp       | rsp_valid / rsp_ready      | status, strip_count, force_valid,
//           |                            | force_index, changed
// csr (APB) | psel, penable, pwrite      | paddr, pwdata, prdata (pready tied high)
//
// One variable per cycle while req_ready is high: each transaction updates the scan registers with a
// few gates; the item carrying last_var also loads the verdict register.
// The verdict appears on rsp in the cycle after its last item is accepted.
// Reset clears the scan state and loads value_s = 0, value_t = 1, direct_mode = 0.
// req_ready drops only while a verdict sits unclaimed in the output register.
module value_precede_propagator
   import vpp_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,

   input  wire                 req_valid,
   output logic                req_ready,
   input  wire                 req_has_s,
   input  wire                 req_has_t,
   input  wire                 req_fixed_s,
   input  wire                 req_fixed_t,
   input  wire                 req_last_var,

   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [STRIP_W-1:0]  rsp_strip_count,
   output logic                rsp_force_valid,
   output logic [FIDX_W-1:0]   rsp_force_index,
   output logic                rsp_changed,

   input  wire                 psel,
   input  wire                 penable,
   input  wire                 pwrite,
   input  wire  [ADDR_W-1:0]   paddr,
   input  wire  [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]   prdata,
   output logic                pready
);

   // ---------------- configuration registers ----------------
   logic [DATA_W-1:0]   value_s_ff, value_s_in;
   logic [DATA_W-1:0]   value_t_ff, value_t_in;
   logic                direct_mode_ff, direct_mode_in;
   logic                csr_write;
   logic [REGSEL_W-1:0] csr_sel;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_sel   = paddr[ADDR_W-1:2];

   always_comb begin
      value_s_in     = value_s_ff;
      value_t_in     = value_t_ff;
      direct_mode_in = direct_mode_ff;
      if (csr_write) begin
         unique case (csr_sel)
            REG_VALUE_S:     value_s_in     = pwdata;
            REG_VALUE_T:     value_t_in     = pwdata;
            REG_DIRECT_MODE: direct_mode_in = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_VALUE_S:     prdata = value_s_ff;
         REG_VALUE_T:     prdata = value_t_ff;
         REG_DIRECT_MODE: prdata = {{(DATA_W-1){1'b0}}, direct_mode_ff};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_s_ff     <= '0;
         value_t_ff     <= {{(DATA_W-1){1'b0}}, 1'b1};
         direct_mode_ff <= 1'b0;
      end else begin
         value_s_ff     <= value_s_in;
         value_t_ff     <= value_t_in;
         direct_mode_ff <= direct_mode_in;
      end
   end

   // ---------------- scan state ----------------
   scan_state_type st_ff, st_in, upd;
   logic           req_fire;
   logic           same;
   logic           in_range;
   logic [IDX_W-1:0] idx;
   logic           fs, ft, hs, ht;

   // A new transaction may enter whenever the verdict slot is free or draining.
   assign req_ready = !rsp_valid || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign same      = (value_s_ff == value_t_ff);
   assign in_range  = (st_ff.position < POS_W'(MAX_VARS));
   assign idx       = st_ff.position[IDX_W-1:0];

   // Normalize flags: fixed implies present; with s == t both values merge.
   always_comb begin
      fs = req_fixed_s;
      ft = req_fixed_t;
      hs = req_has_s || req_fixed_s;
      ht = req_has_t || req_fixed_t;
      if (same) begin
         fs = req_fixed_s || req_fixed_t;
         ft = fs;
         hs = req_has_s || req_has_t || req_fixed_s || req_fixed_t;
         ht = hs;
      end
   end

   always_comb begin
      upd = st_ff;
      if (in_range) begin
         // Strip range: everything up to and including alpha.
         if (!st_ff.first_s_found) begin
            if (ht) upd.strip_happened = 1'b1;
            if (ft) upd.strip_failed   = 1'b1;
            if (hs) begin
               upd.first_s_found    = 1'b1;
               upd.first_s_index    = idx;
               upd.first_s_is_fixed = fs;
            end
         end
         // Region before gamma: count s supports (saturating at two).
         if (!st_ff.first_fixed_t_found) begin
            if (ht) upd.t_seen_before_gamma = 1'b1;
            if (ft) begin
               upd.first_fixed_t_found = 1'b1;
               upd.first_fixed_t_index = idx;
            end else if (hs && (st_ff.s_support_count < 2'd2)) begin
               upd.s_support_count = st_ff.s_support_count + 2'd1;
            end
         end
         upd.position = st_ff.position + POS_W'(1);
      end
   end

   always_comb begin
      st_in = st_ff;
      if (req_fire) begin
         st_in = req_last_var ? '0 : upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else begin
         st_ff <= st_in;
      end
   end

   // ---------------- verdict ----------------
   logic [STATUS_W-1:0] v_status;
   logic [STRIP_W-1:0]  v_strip;
   logic                v_fvalid;
   logic [FIDX_W-1:0]   v_findex;
   logic                v_changed;
   logic [STRIP_W-1:0]  n_vars;
   logic [STRIP_W-1:0]  alpha_plus_one;

   assign n_vars         = STRIP_W'(upd.position);
   assign alpha_plus_one = STRIP_W'(upd.first_s_index) + STRIP_W'(1);

   always_comb begin
      v_status  = STATUS_OK;
      v_strip   = '0;
      v_fvalid  = 1'b0;
      v_findex  = '0;
      v_changed = 1'b0;
      if (same) begin
         // s == t: s goes from every variable.
         if (direct_mode_ff && upd.first_fixed_t_found) begin
            v_status = STATUS_CONTRA;
         end else begin
            v_status  = direct_mode_ff ? STATUS_OK : STATUS_ENTAILED;
            v_strip   = n_vars;
            v_changed = upd.first_s_found;
         end
      end else if (direct_mode_ff && upd.strip_failed) begin
         v_status = STATUS_CONTRA;
      end else begin
         v_strip   = upd.first_s_found ? alpha_plus_one : n_vars;
         v_changed = upd.strip_happened;
         priority if (!direct_mode_ff && upd.first_s_found && upd.first_s_is_fixed) begin
            v_status = STATUS_ENTAILED;
         end else if (!direct_mode_ff && !upd.first_fixed_t_found
                      && !upd.t_seen_before_gamma) begin
            v_status = STATUS_ENTAILED;
         end else if (upd.first_fixed_t_found) begin
            // gamma must come after alpha; a lone support before gamma is forced.
            if (!upd.first_s_found
                || (upd.first_s_index >= upd.first_fixed_t_index)) begin
               v_status = STATUS_CONTRA;
            end else if ((upd.s_support_count == 2'd1) && !upd.first_s_is_fixed) begin
               v_fvalid  = 1'b1;
               v_findex  = FIDX_W'(upd.first_s_index);
               v_changed = 1'b1;
            end
         end else begin
            v_status = STATUS_OK;
         end
      end
      if (v_status == STATUS_CONTRA) begin
         v_strip   = '0;
         v_fvalid  = 1'b0;
         v_findex  = '0;
         v_changed = 1'b0;
      end
   end

   // ---------------- output register ----------------
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [STRIP_W-1:0]  rsp_strip_ff, rsp_strip_in;
   logic                rsp_fvalid_ff, rsp_fvalid_in;
   logic [FIDX_W-1:0]   rsp_findex_ff, rsp_findex_in;
   logic                rsp_changed_ff, rsp_changed_in;
   logic                load_verdict;

   assign load_verdict = req_fire && req_last_var;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_strip_in   = rsp_strip_ff;
      rsp_fvalid_in  = rsp_fvalid_ff;
      rsp_findex_in  = rsp_findex_ff;
      rsp_changed_in = rsp_changed_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (load_verdict) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = v_status;
         rsp_strip_in   = v_strip;
         rsp_fvalid_in  = v_fvalid;
         rsp_findex_in  = v_findex;
         rsp_changed_in = v_changed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_strip_ff   <= rsp_strip_in;
      rsp_fvalid_ff  <= rsp_fvalid_in;
      rsp_findex_ff  <= rsp_findex_in;
      rsp_changed_ff <= rsp_changed_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_strip_count = rsp_strip_ff;
   assign rsp_force_valid = rsp_fvalid_ff;
   assign rsp_force_index = rsp_findex_ff;
   assign rsp_changed     = rsp_changed_ff;

`ifndef SYNTHESIS
   a_contra_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_CONTRA) |->
         (rsp_strip_count == '0) && !rsp_force_valid && !rsp_changed)
      else $error("contradiction verdict carries nonzero payload");

   a_force_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_force_valid |-> rsp_changed && (rsp_status == STATUS_OK))
      else $error("forced assignment without ok status or change flag");

   a_last_gives_verdict: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_var |=> rsp_valid && (st_ff.position == '0))
      else $error("closing transaction did not produce verdict or clear scan");

   a_strip_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_strip_count <= STRIP_W'(MAX_VARS)))
      else $error("strip count beyond sequence limit");

   a_position_bound: assert property (@(posedge clock) disable iff (reset)
      st_ff.position <= POS_W'(MAX_VARS))
      else $error("position counter overran");
`endif

endmodule

`default_nettype wire

@@ verif/tb_value_precede_propagator.sv @@
// Self-checking testbench for the value-precedence propagator: random and directed streams.
`timescale 1ns / 1ps

module tb_value_precede_propagator
   import vpp_pkg::*;
;

   // Run limits: generous cycle cap, length of the forced receiver hold-off, random item budget and settle time.
   localparam int CYCLE_LIMIT   = 400000;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_ITEMS  = 1050;
   localparam int SETTLE_CYCLES = 4;

   // One verdict as it leaves the rsp channel.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [STRIP_W-1:0]  strip_count;
      logic                force_valid;
      logic [FIDX_W-1:0]   force_index;
      logic                changed;
   } verdict_type;

   // Tracks the register copy and scan state, predicts one verdict per sequence
   // and compares arriving verdicts against the oldest prediction.
   class verdict_scoreboard;
      logic [DATA_W-1:0] value_s;
      logic [DATA_W-1:0] value_t;
      logic              direct;
      scan_state_type    scan;
      verdict_type       expected_verdicts[$];
      int                mismatches;
      int                verdicts_checked;

      function new();
         value_s          = '0;
         value_t          = 32'd1;
         direct           = 1'b0;
         scan             = '0;
         mismatches       = 0;
         verdicts_checked = 0;
      endfunction

      function void write_reg(input logic [REGSEL_W-1:0] idx, input logic [DATA_W-1:0] data);
         case (idx)
            REG_VALUE_S:     value_s = data;
            REG_VALUE_T:     value_t = data;
            REG_DIRECT_MODE: direct  = data[0];
            default: ;
         endcase
      endfunction

      function logic [DATA_W-1:0] reg_value(input logic [REGSEL_W-1:0] idx);
         case (idx)
            REG_VALUE_S:     return value_s;
            REG_VALUE_T:     return value_t;
            REG_DIRECT_MODE: return {{(DATA_W-1){1'b0}}, direct};
            default:         return '0;
         endcase
      endfunction

      function int pending();
         return expected_verdicts.size();
      endfunction

      function void report(input string what);
         mismatches++;
         if (mismatches <= 10) $display("[%0t] MISMATCH: %s", $realtime, what);
      endfunction

      function void compare_reg(input logic [REGSEL_W-1:0] idx, input logic [DATA_W-1:0] got);
         logic [DATA_W-1:0] want;
         want = reg_value(idx);
         if (got !== want)
            report($sformatf("register %0d read back %h, expected %h", idx, got, want));
      endfunction

      // Fold one accepted variable into the scan; a closing variable yields a verdict.
      function void note_variable(input logic hs_in, input logic ht_in, input logic fs_in,
                                  input logic ft_in, input logic last);
         logic        same;
         logic        hs, ht, fs, ft;
         verdict_type v;
         logic [STRIP_W-1:0] n;
         same = (value_s == value_t);
         fs   = fs_in;
         ft   = ft_in;
         hs   = hs_in | fs_in;
         ht   = ht_in | ft_in;
         if (same) begin
            fs = fs | ft;
            ft = fs;
            hs = hs | ht;
            ht = hs;
         end
         if (scan.position < MAX_VARS) begin
            // Still in the strip range up to alpha
            if (!scan.first_s_found) begin
               if (ht) scan.strip_happened = 1'b1;
               if (ft) scan.strip_failed = 1'b1;
               if (hs) begin
                  scan.first_s_found    = 1'b1;
                  scan.first_s_index    = scan.position[IDX_W-1:0];
                  scan.first_s_is_fixed = fs;
               end
            end
            // Looking for gamma, counting s supports on the way
            if (!scan.first_fixed_t_found) begin
               if (ht) scan.t_seen_before_gamma = 1'b1;
               if (ft) begin
                  scan.first_fixed_t_found = 1'b1;
                  scan.first_fixed_t_index = scan.position[IDX_W-1:0];
               end else if (hs && scan.s_support_count < 2) begin
                  scan.s_support_count = scan.s_support_count + 1'b1;
               end
            end
            scan.position = scan.position + 1'b1;
         end
         if (!last) return;

         n = STRIP_W'(scan.position);
         v = '0;
         v.status = STATUS_OK;
         if (same) begin
            if (direct && scan.first_fixed_t_found) begin
               v.status = STATUS_CONTRA;
            end else begin
               v.status      = direct ? STATUS_OK : STATUS_ENTAILED;
               v.strip_count = n;
               v.changed     = scan.first_s_found;
            end
         end else if (direct && scan.strip_failed) begin
            v.status = STATUS_CONTRA;
         end else begin
            v.strip_count = scan.first_s_found ?
                            STRIP_W'(scan.first_s_index) + 1'b1 : n;
            v.changed     = scan.strip_happened;
            if (!direct && scan.first_s_found && scan.first_s_is_fixed) begin
               v.status = STATUS_ENTAILED;
            end else if (!direct && !scan.first_fixed_t_found &&
                         !scan.t_seen_before_gamma) begin
               v.status = STATUS_ENTAILED;
            end else if (scan.first_fixed_t_found) begin
               if (!scan.first_s_found ||
                   scan.first_s_index >= scan.first_fixed_t_index) begin
                  v.status = STATUS_CONTRA;
               end else if (scan.s_support_count == 2'd1 && !scan.first_s_is_fixed) begin
                  v.force_valid = 1'b1;
                  v.force_index = FIDX_W'(scan.first_s_index);
                  v.changed     = 1'b1;
               end
            end
         end
         if (v.status == STATUS_CONTRA) begin
            v.strip_count = '0;
            v.force_valid = 1'b0;
            v.force_index = '0;
            v.changed     = 1'b0;
         end
         expected_verdicts.push_back(v);
         scan = '0;
      endfunction

      function void check_verdict(input verdict_type got);
         verdict_type want;
         if (expected_verdicts.size() == 0) begin
            report($sformatf({"verdict with none expected:",
                              " status=%0d strip=%0d force=%0b/%0d chg=%0b"},
                             got.status, got.strip_count, got.force_valid,
                             got.force_index, got.changed));
            return;
         end
         want = expected_verdicts.pop_front();
         verdicts_checked++;
         if (got.status !== want.status || got.strip_count !== want.strip_count ||
             got.force_valid !== want.force_valid || got.force_index !== want.force_index ||
             got.changed !== want.changed)
            report($sformatf({"verdict %0d expected status=%0d strip=%0d force=%0b/%0d chg=%0b,",
                              " got status=%0d strip=%0d force=%0b/%0d chg=%0b"},
                             verdicts_checked, want.status, want.strip_count,
                             want.force_valid, want.force_index, want.changed,
                             got.status, got.strip_count, got.force_valid,
                             got.force_index, got.changed));
      endfunction
   endclass

   // DUT inputs, all known from time zero
   logic                clock        = 1'b0;
   logic                reset        = 1'b1;
   logic                req_valid    = 1'b0;
   logic                req_has_s    = 1'b0;
   logic                req_has_t    = 1'b0;
   logic                req_fixed_s  = 1'b0;
   logic                req_fixed_t  = 1'b0;
   logic                req_last_var = 1'b0;
   logic                rsp_ready    = 1'b0;
   logic                psel         = 1'b0;
   logic                penable      = 1'b0;
   logic                pwrite       = 1'b0;
   logic [ADDR_W-1:0]   paddr        = '0;
   logic [DATA_W-1:0]   pwdata       = '0;

   // DUT outputs
   logic                req_ready;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [STRIP_W-1:0]  rsp_strip_count;
   logic                rsp_force_valid;
   logic [FIDX_W-1:0]   rsp_force_index;
   logic                rsp_changed;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   // Traffic shaping shared between the stimulus and the receiver
   logic                no_gaps      = 1'b0;
   logic                hold_request = 1'b0;
   int                  hold_left    = 0;

   int                  items_sent   = 0;
   int                  sequences    = 0;
   int                  csr_writes   = 0;

   verdict_scoreboard   sb = new();

   value_precede_propagator dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_has_s       (req_has_s),
      .req_has_t       (req_has_t),
      .req_fixed_s     (req_fixed_s),
      .req_fixed_t     (req_fixed_t),
      .req_last_var    (req_last_var),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_strip_count (rsp_strip_count),
      .rsp_force_valid (rsp_force_valid),
      .rsp_force_index (rsp_force_index),
      .rsp_changed     (rsp_changed),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: the run must finish well inside this many cycles.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d verdicts still expected",
               CYCLE_LIMIT, sb.pending());
      $display("tb_value_precede_propagator failed");
      $finish;
   end

   // Receiver: random back-pressure, a no-stall window, and one long hold-off
   // whose length is counted here rather than by the stimulus.
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_gaps || ($urandom_range(99) >= 9);
      end
   end

   // Result monitor: every rsp transaction goes to the scoreboard. Sampled values
   // are the ones in force just before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_verdict('{status:      rsp_status,
                            strip_count: rsp_strip_count,
                            force_valid: rsp_force_valid,
                            force_index: rsp_force_index,
                            changed:     rsp_changed});
   end

   function automatic bit chance(input int pct);
      return $urandom_range(99) < pct;
   endfunction

   // Offer one variable; returns once the req transaction has been accepted.
   // valid is left high so back-to-back items never toggle it within a step.
   task automatic send_variable(input logic hs, input logic ht, input logic fs,
                                input logic ft, input logic last);
      while (!no_gaps && chance(9)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_has_s    <= hs;
      req_has_t    <= ht;
      req_fixed_s  <= fs;
      req_fixed_t  <= ft;
      req_last_var <= last;
      do @(posedge clock); while (!req_ready);
      sb.note_variable(hs, ht, fs, ft, last);
      items_sent++;
      if (last) sequences++;
   endtask

   // Stop offering, wait for every outstanding verdict, then let the pipe settle.
   task automatic drain_results(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // APB write: setup phase, then access phase until pready, then idle.
   task automatic csr_write(input logic [REGSEL_W-1:0] idx, input logic [DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(idx) << 2;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      sb.write_reg(idx, data);
      csr_writes++;
      @(posedge clock);
   endtask

   // APB read with readback compare; prdata is taken at the completing edge.
   task automatic csr_check(input logic [REGSEL_W-1:0] idx);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_W'(idx) << 2;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.compare_reg(idx, prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // One sequence with per-flag densities in percent.
   task automatic send_sequence(input int len, input int p_hs, input int p_ht,
                                input int p_fs, input int p_ft);
      for (int i = 0; i < len; i++)
         send_variable(chance(p_hs), chance(p_ht), chance(p_fs), chance(p_ft), i == len - 1);
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(5))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Phase boundary: new s/t/mode, s == t about a third of the time.
   task automatic reconfigure();
      logic [DATA_W-1:0] s_val;
      logic [DATA_W-1:0] t_val;
      s_val = pick_value();
      t_val = chance(30) ? s_val : pick_value();
      drain_results(SETTLE_CYCLES);
      csr_write(REG_VALUE_S, s_val);
      csr_write(REG_VALUE_T, t_val);
      csr_write(REG_DIRECT_MODE, {$urandom} ^ {31'd0, chance(50)});
      csr_check(REGSEL_W'($urandom_range(2)));
   endtask

   initial begin
      int len;
      int random_items;
      int seq_idx;
      int long_done;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values of all three registers
      csr_check(REG_VALUE_S);
      csr_check(REG_VALUE_T);
      csr_check(REG_DIRECT_MODE);

      // ---- Directed part: search mode, s = 0, t = 1 ----
      // No alpha, no t anywhere: entailed
      send_variable(1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
      // alpha is the lone support before gamma: force alpha to s
      send_variable(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
      send_variable(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
      send_variable(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
      // gamma with no alpha in front: contradiction
      send_variable(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
      // alpha already fixed to s: entailed; fixed flags without has flags
      send_variable(1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
      send_variable(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
      // Every flag high on one variable
      send_variable(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);

      // ---- Direct mode: removing a fixed t is a contradiction ----
      drain_results(SETTLE_CYCLES);
      csr_write(REG_DIRECT_MODE, 32'hFFFF_FFFF);
      csr_check(REG_DIRECT_MODE);
      send_variable(1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
      send_variable(1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
      send_variable(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
      send_variable(1'b1, 1'b0, 1'b0, 1'b0, 1'b1);

      // ---- s equals t at the negative extreme, direct then search ----
      drain_results(SETTLE_CYCLES);
      csr_write(REG_VALUE_S, 32'h8000_0000);
      csr_write(REG_VALUE_T, 32'h8000_0000);
      send_variable(1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
      send_variable(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
      send_variable(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_variable(1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
      drain_results(SETTLE_CYCLES);
      csr_write(REG_DIRECT_MODE, 32'hFFFF_FFFE);
      send_variable(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      send_variable(1'b1, 1'b0, 1'b0, 1'b0, 1'b1);

      // ---- Register change in the middle of a sequence ----
      // s != t for the first variable, then s == t for the closing one.
      drain_results(SETTLE_CYCLES);
      csr_write(REG_VALUE_S, 32'h7FFF_FFFF);
      csr_write(REG_VALUE_T, 32'hFFFF_FFFF);
      send_variable(1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
      drain_results(SETTLE_CYCLES);
      csr_write(REG_VALUE_T, 32'h7FFF_FFFF);
      send_variable(1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
      drain_results(SETTLE_CYCLES);
      csr_write(REG_VALUE_S, 32'hFFFF_FFFF);
      csr_write(REG_VALUE_T, 32'h0000_0000);
      csr_check(REG_VALUE_S);
      csr_check(REG_VALUE_T);

      // ---- Random part ----
      random_items = 0;
      seq_idx      = 0;
      long_done    = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (seq_idx % 12 == 11) reconfigure();

         // Window with no idling on either side
         if (seq_idx == 40) no_gaps <= 1'b1;
         if (seq_idx == 70) no_gaps <= 1'b0;

         if (seq_idx == 25) begin
            // Receiver holds off while short sequences keep coming, so the
            // verdict register fills and req stalls; then the sender pauses
            // until every verdict is home.
            hold_request <= 1'b1;
            for (int k = 0; k < 6; k++) begin
               len = $urandom_range(1, 3);
               send_sequence(len, 40, 40, 15, 15);
               random_items += len;
            end
            drain_results(0);
         end

         if ((seq_idx == 3 && long_done == 0) || (seq_idx > 3 && chance(2) && long_done < 3)) begin
            // At and around the variable limit; sparse s pushes alpha deep
            len = (long_done == 0) ? MAX_VARS : $urandom_range(MAX_VARS - 6, MAX_VARS + 44);
            send_sequence(len, chance(50) ? 0 : 1, 30, 1, chance(50) ? 0 : 1);
            long_done++;
         end else begin
            len = $urandom_range(1, 12);
            case ($urandom_range(3))
               0: send_sequence(len, 50, 50, 50, 50);
               1: send_sequence(len, 15, 40, 5, 10);
               2: send_sequence(len, 40, 70, 20, 5);
               default: send_sequence(len, 3, 10, 0, 20);
            endcase
         end
         random_items += len;
         seq_idx++;
      end

      // Wind down: all verdicts in, then quiet settling for strays.
      drain_results(20);
      $display("covered %0d variables in %0d sequences, %0d verdicts checked, %0d register writes",
               items_sent, sequences, sb.verdicts_checked, csr_writes);
      $display("mismatches: %0d", sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("tb_value_precede_propagator passed");
      end else begin
         $display("tb_value_precede_propagator failed");
      end
      $finish;
   end

endmodule
